### rtl/hcm_pkg.sv
// Shared types, constants and mod-26 helpers for the 2x2 Hill cipher block.
// No dependencies; compiled first.
`default_nettype none

package hcm_pkg;

  localparam int MODULUS    = 26;
  localparam int UPPER_BASE = 65;
  localparam int CASE_SHIFT = 32;
  // floor(x * RECIP / 2^16) == floor(x / 26) for every x below 2048
  localparam int RECIP      = 2521;

  localparam int LETTER_W = 5;
  localparam int CHAR_W   = 7;
  localparam int IDX_W    = 3;
  localparam int DATA_W   = 5;
  localparam int SUM_W    = 11;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [CHAR_W-1:0]   char_t;

  typedef enum logic [IDX_W-1:0] {
    REG_KEY_A   = 3'd0,
    REG_KEY_B   = 3'd1,
    REG_KEY_C   = 3'd2,
    REG_KEY_D   = 3'd3,
    REG_DECRYPT = 3'd4
  } cfg_reg_t;

  // Effective matrix and status handed from the key unit to the datapath
  typedef struct packed {
    letter_t m00;
    letter_t m01;
    letter_t m10;
    letter_t m11;
    logic    ok;
    logic    decrypt;
    logic    busy;
  } key_ctl_t;

  typedef struct packed {
    letter_t p0;
    letter_t p1;
  } pair_t;

  // Reduce a 5-bit value (0..31) to 0..25
  function automatic letter_t reduce5(input letter_t x);
    letter_t r;
    r = (x >= letter_t'(MODULUS)) ? letter_t'(x - letter_t'(MODULUS)) : x;
    return r;
  endfunction

  // x mod 26 for x < 2048, by reciprocal multiply
  function automatic letter_t mod26(input logic [SUM_W-1:0] x);
    logic [22:0]      prod;
    logic [6:0]       q;
    logic [SUM_W-1:0] r;
    prod = 23'(x) * 23'(RECIP);
    q    = prod[22:16];
    r    = x - SUM_W'(q) * SUM_W'(MODULUS);
    return r[LETTER_W-1:0];
  endfunction

  // Multiplicative inverse mod 26; returns {ok, inverse}
  function automatic logic [LETTER_W:0] inv_mod26(input letter_t v);
    logic [LETTER_W:0] r;
    unique case (v)
      5'd1:    r = {1'b1, 5'd1};
      5'd3:    r = {1'b1, 5'd9};
      5'd5:    r = {1'b1, 5'd21};
      5'd7:    r = {1'b1, 5'd15};
      5'd9:    r = {1'b1, 5'd3};
      5'd11:   r = {1'b1, 5'd19};
      5'd15:   r = {1'b1, 5'd7};
      5'd17:   r = {1'b1, 5'd23};
      5'd19:   r = {1'b1, 5'd11};
      5'd21:   r = {1'b1, 5'd5};
      5'd23:   r = {1'b1, 5'd17};
      5'd25:   r = {1'b1, 5'd25};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/hcm_if.sv
// Valid/ready channel interfaces: letter input, character output, config writes.
// Depends on hcm_pkg.
`default_nettype none

interface hcm_in_if;
  logic             valid;
  logic             ready;
  hcm_pkg::letter_t letter;
  logic             end_of_text;

  modport source (output valid, letter, end_of_text, input ready);
  modport sink   (input valid, letter, end_of_text, output ready);
endinterface

interface hcm_out_if;
  logic           valid;
  logic           ready;
  hcm_pkg::char_t out_char;
  logic           pair_last;
  logic           key_error;

  modport source (output valid, out_char, pair_last, key_error, input ready);
  modport sink   (input valid, out_char, pair_last, key_error, output ready);
endinterface

interface hcm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [hcm_pkg::IDX_W-1:0]     index;
  logic [hcm_pkg::DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/hill_cipher_2x2_mod26_top.sv
// 2x2 Hill cipher mod 26, one letter request per cycle unless held off by a key write or output stall.
// A letter that completes a pair is registered in the pair register, then taken into the output buffer,
// which offers its first character and then its second. Throughput: 1 letter/cycle sustained while the
// output is ready, set by the pair register and the two-entry output buffer; a lone end-of-text letter
// is padded and still costs two characters of output.
// Reset (rst, synchronous): key = identity, encrypt, pairing cleared; letters are held off
// after reset and after every key write while the derived matrix settles.
`default_nettype none

module hill_cipher_2x2_mod26_top (
  input  wire logic clk,
  input  wire logic rst,
  hcm_in_if.sink    letters,
  hcm_out_if.source results,
  hcm_cfg_if.sink   cfg
);
  import hcm_pkg::*;

  key_ctl_t ctl;
  pair_t    pair;
  logic     pair_valid;
  logic     take;

  hcm_key u_key (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .ctl (ctl)
  );

  hcm_pair u_pair (
    .clk        (clk),
    .rst        (rst),
    .letters    (letters),
    .busy       (ctl.busy),
    .take       (take),
    .pair_valid (pair_valid),
    .pair       (pair)
  );

  hcm_out u_out (
    .clk        (clk),
    .rst        (rst),
    .pair_valid (pair_valid),
    .pair       (pair),
    .ctl        (ctl),
    .take       (take),
    .results    (results)
  );

endmodule

`default_nettype wire

### rtl/hcm_key.sv
// Key registers and derived effective matrix (key or its inverse mod 26).
// Depends on hcm_pkg and hcm_cfg_if.
`default_nettype none

module hcm_key (
  input  wire logic          clk,
  input  wire logic          rst,
  hcm_cfg_if.sink            cfg,
  output hcm_pkg::key_ctl_t  ctl
);
  import hcm_pkg::*;

  letter_t   key_a, key_b, key_c, key_d;
  logic      decrypt_mode;
  logic [1:0] settle;

  // stage A: reduced key and determinant
  letter_t   ra, rb, rc, rd, det;
  logic      mode_a;
  // stage B: effective matrix
  letter_t   m00, m01, m10, m11;
  logic      ok, mode_b;

  logic              wr;
  logic [9:0]        ad, bc;
  letter_t           ra_next, rb_next, rc_next, rd_next, det_next;
  logic [LETTER_W:0] inv;
  letter_t           dinv;
  letter_t           nb, nc;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_a        <= letter_t'(1);
      key_b        <= '0;
      key_c        <= '0;
      key_d        <= letter_t'(1);
      decrypt_mode <= 1'b0;
    end else if (wr) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_KEY_A:   key_a <= cfg.data;
        REG_KEY_B:   key_b <= cfg.data;
        REG_KEY_C:   key_c <= cfg.data;
        REG_KEY_D:   key_d <= cfg.data;
        REG_DECRYPT: decrypt_mode <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // hold off letters until both derived stages reflect the newest key
  always_ff @(posedge clk) begin
    if (rst || wr) begin
      settle <= 2'd2;
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  always_comb begin
    ra_next  = reduce5(key_a);
    rb_next  = reduce5(key_b);
    rc_next  = reduce5(key_c);
    rd_next  = reduce5(key_d);
    ad       = 10'(ra_next) * 10'(rd_next);
    bc       = 10'(rb_next) * 10'(rc_next);
    det_next = mod26(SUM_W'(ad) + SUM_W'(MODULUS * MODULUS) - SUM_W'(bc));
  end

  always_ff @(posedge clk) begin
    ra     <= ra_next;
    rb     <= rb_next;
    rc     <= rc_next;
    rd     <= rd_next;
    det    <= det_next;
    mode_a <= decrypt_mode;
  end

  always_comb begin
    inv  = inv_mod26(det);
    dinv = inv[LETTER_W-1:0];
    nb   = letter_t'(MODULUS) - rb;
    nc   = letter_t'(MODULUS) - rc;
  end

  always_ff @(posedge clk) begin
    ok     <= inv[LETTER_W];
    mode_b <= mode_a;
    if (mode_a) begin
      m00 <= mod26(SUM_W'(dinv) * SUM_W'(rd));
      m01 <= mod26(SUM_W'(dinv) * SUM_W'(nb));
      m10 <= mod26(SUM_W'(dinv) * SUM_W'(nc));
      m11 <= mod26(SUM_W'(dinv) * SUM_W'(ra));
    end else begin
      m00 <= ra;
      m01 <= rb;
      m10 <= rc;
      m11 <= rd;
    end
  end

  assign ctl = '{m00: m00, m01: m01, m10: m10, m11: m11,
                 ok: ok, decrypt: mode_b, busy: (settle != 2'd0)};

endmodule

`default_nettype wire

### rtl/hcm_pair.sv
// Letter pairing: holds the first letter of a pair, registers completed pairs.
// Depends on hcm_pkg and hcm_in_if.
`default_nettype none

module hcm_pair (
  input  wire logic      clk,
  input  wire logic      rst,
  hcm_in_if.sink         letters,
  input  wire logic      busy,
  input  wire logic      take,
  output logic           pair_valid,
  output hcm_pkg::pair_t pair
);
  import hcm_pkg::*;

  letter_t held_letter;
  logic    half_pair_held;
  logic    accept, completes, pair_valid_next;
  letter_t letter_r;

  assign letters.ready = !busy && (!pair_valid || take);
  assign accept        = letters.valid && letters.ready;
  assign letter_r      = reduce5(letters.letter);
  assign completes     = half_pair_held || letters.end_of_text;
  assign pair_valid_next = (pair_valid && !take) || (accept && completes);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_letter    <= '0;
      half_pair_held <= 1'b0;
      pair_valid     <= 1'b0;
    end else begin
      pair_valid <= pair_valid_next;
      if (accept) begin
        if (completes) begin
          held_letter    <= '0;
          half_pair_held <= 1'b0;
        end else begin
          held_letter    <= letter_r;
          half_pair_held <= 1'b1;
        end
      end
    end
  end

  // unpaired final letter is padded with letter 0
  always_ff @(posedge clk) begin
    if (accept && completes) begin
      pair.p0 <= half_pair_held ? held_letter : letter_r;
      pair.p1 <= half_pair_held ? letter_r : '0;
    end
  end

endmodule

`default_nettype wire

### rtl/hcm_out.sv
// Pair product mod 26, character mapping and two-entry result serializer.
// Depends on hcm_pkg and hcm_out_if.
`default_nettype none

module hcm_out (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              pair_valid,
  input  wire hcm_pkg::pair_t    pair,
  input  wire hcm_pkg::key_ctl_t ctl,
  output logic                   take,
  hcm_out_if.source              results
);
  import hcm_pkg::*;

  char_t   char0, char1;
  logic    err;
  logic    ob_valid, ob_second;
  letter_t v0, v1;
  char_t   base;
  logic    out_done;

  always_comb begin
    v0   = mod26(SUM_W'(ctl.m00) * SUM_W'(pair.p0) + SUM_W'(ctl.m01) * SUM_W'(pair.p1));
    v1   = mod26(SUM_W'(ctl.m10) * SUM_W'(pair.p0) + SUM_W'(ctl.m11) * SUM_W'(pair.p1));
    base = char_t'(UPPER_BASE) + (ctl.decrypt ? char_t'(CASE_SHIFT) : '0);
  end

  assign out_done = results.valid && results.ready;
  assign take     = pair_valid && (!ob_valid || (ob_second && results.ready));

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_valid  <= 1'b0;
      ob_second <= 1'b0;
    end else if (take) begin
      ob_valid  <= 1'b1;
      ob_second <= 1'b0;
    end else if (out_done) begin
      ob_valid  <= !ob_second;
      ob_second <= !ob_second;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      char0 <= ctl.ok ? char_t'(base + char_t'(v0)) : '0;
      char1 <= ctl.ok ? char_t'(base + char_t'(v1)) : '0;
      err   <= !ctl.ok;
    end
  end

  assign results.valid     = ob_valid;
  assign results.out_char  = ob_second ? char1 : char0;
  assign results.pair_last = ob_second;
  assign results.key_error = err;

endmodule

`default_nettype wire

### test/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for hill_cipher_2x2_mod26_top: directed letter pairs, then random rounds.
// Each round loads a new key and mode, and every character out is checked against a pair predictor.
// Depends on hcm_pkg, hcm_if and the top-level RTL.

module tb;
  import hcm_pkg::*;

  typedef struct packed {
    letter_t ltr;
    logic    eot;
  } letter_req_t;

  typedef struct packed {
    char_t ch;
    logic  last;
    logic  err;
  } cipher_char_t;

  logic clk;
  logic rst;

  hcm_in_if  letters_if();
  hcm_out_if results_if();
  hcm_cfg_if cfg_if();

  hill_cipher_2x2_mod26_top uut (
    .clk     (clk),
    .rst     (rst),
    .letters (letters_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  letter_req_t  letter_queue[$];
  cipher_char_t chars_due[$];

  // key/mode shadow, updated on each accepted register write
  logic [DATA_W-1:0] key_a_sh, key_b_sh, key_c_sh, key_d_sh;
  logic              decrypt_sh;
  int                held_ltr;
  bit                half_held;

  int  src_idle_pct;
  int  snk_idle_pct;
  int  hold_req;
  int  hold_seen;
  int  hold_cnt;
  logic in_fire;

  int mismatch_cnt;
  int letters_taken;
  int chars_seen;
  int err_chars;
  int dec_chars;
  int reg_writes;
  int key_loads;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d requests still queued, %0d characters outstanding",
             letter_queue.size(), chars_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void note_mismatch(input string what, input cipher_char_t exp_c,
                                        input cipher_char_t act_c);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t: %s: expected char=%0d last=%0b err=%0b, got char=%0d last=%0b err=%0b",
               $realtime, what, exp_c.ch, exp_c.last, exp_c.err, act_c.ch, act_c.last,
               act_c.err);
  endfunction

  // Pair up letters; a completed pair yields two characters under the current key and mode.
  function automatic void predict_letter(input letter_t raw, input logic eot);
    int ltr, p0, p1, a, b, c, d, det, dinv;
    int m00, m01, m10, m11, v0, v1, ch;
    bit inv_ok;
    cipher_char_t r;
    ltr = raw % MODULUS;
    if (!half_held && !eot) begin
      held_ltr  = ltr;
      half_held = 1'b1;
      return;
    end
    p0 = half_held ? held_ltr : ltr;
    p1 = half_held ? ltr : 0;
    held_ltr  = 0;
    half_held = 1'b0;

    a = key_a_sh % MODULUS;
    b = key_b_sh % MODULUS;
    c = key_c_sh % MODULUS;
    d = key_d_sh % MODULUS;
    det = (a * d + MODULUS * MODULUS - b * c) % MODULUS;
    inv_ok = 1'b0;
    dinv   = 0;
    for (int i = 1; i < MODULUS; i++)
      if (!inv_ok && (det * i) % MODULUS == 1) begin
        dinv   = i;
        inv_ok = 1'b1;
      end

    if (decrypt_sh) begin
      // adjugate scaled by det^-1
      m00 = (dinv * d) % MODULUS;
      m01 = (dinv * (MODULUS - b)) % MODULUS;
      m10 = (dinv * (MODULUS - c)) % MODULUS;
      m11 = (dinv * a) % MODULUS;
    end else begin
      m00 = a;
      m01 = b;
      m10 = c;
      m11 = d;
    end
    v0 = (m00 * p0 + m01 * p1) % MODULUS;
    v1 = (m10 * p0 + m11 * p1) % MODULUS;

    for (int k = 0; k < 2; k++) begin
      ch     = UPPER_BASE + ((k == 1) ? v1 : v0) + (decrypt_sh ? CASE_SHIFT : 0);
      r.ch   = inv_ok ? char_t'(ch) : '0;
      r.last = (k == 1);
      r.err  = !inv_ok;
      chars_due.push_back(r);
    end
  endfunction

  // letter driver
  always @(negedge clk) begin
    letter_req_t item;
    if (rst) begin
      letters_if.valid <= 1'b0;
    end else if (!letters_if.valid || in_fire) begin
      if (letter_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        item = letter_queue.pop_front();
        letters_if.valid       <= 1'b1;
        letters_if.letter      <= item.ltr;
        letters_if.end_of_text <= item.eot;
      end else begin
        letters_if.valid <= 1'b0;
      end
    end
  end

  // output ready, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen        <= hold_req;
      hold_cnt         <= 150;
      results_if.ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt         <= hold_cnt - 1;
      results_if.ready <= 1'b0;
    end else begin
      results_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    cipher_char_t exp_c;
    cipher_char_t act_c;
    in_fire <= letters_if.valid && letters_if.ready;
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) begin
        reg_writes++;
        case (cfg_reg_t'(cfg_if.index))
          REG_KEY_A:   key_a_sh   = cfg_if.data;
          REG_KEY_B:   key_b_sh   = cfg_if.data;
          REG_KEY_C:   key_c_sh   = cfg_if.data;
          REG_KEY_D:   key_d_sh   = cfg_if.data;
          REG_DECRYPT: decrypt_sh = cfg_if.data[0];
          default: ;
        endcase
      end
      if (letters_if.valid && letters_if.ready) begin
        letters_taken++;
        predict_letter(letters_if.letter, letters_if.end_of_text);
      end
      if (results_if.valid && results_if.ready) begin
        act_c.ch   = results_if.out_char;
        act_c.last = results_if.pair_last;
        act_c.err  = results_if.key_error;
        chars_seen++;
        if (chars_due.size() == 0) begin
          note_mismatch("unexpected character", '0, act_c);
        end else begin
          exp_c = chars_due.pop_front();
          if (exp_c.err)
            err_chars++;
          else if (exp_c.ch >= char_t'(UPPER_BASE + CASE_SHIFT))
            dec_chars++;
          if (exp_c.ch !== act_c.ch || exp_c.last !== act_c.last || exp_c.err !== act_c.err)
            note_mismatch("character mismatch", exp_c, act_c);
        end
      end
    end
  end

  task automatic send(input int ltr, input logic eot);
    letter_req_t item;
    item.ltr = letter_t'(ltr);
    item.eot = eot;
    letter_queue.push_back(item);
  endtask

  // all requests taken and all characters back, plus room for a held first letter
  task automatic wait_idle();
    do @(posedge clk);
    while (letter_queue.size() != 0 || letters_if.valid || chars_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  task automatic load_key(input int a, input int b, input int c, input int d,
                          input logic dec);
    wait_idle();
    write_reg(REG_KEY_A, DATA_W'(a));
    write_reg(REG_KEY_B, DATA_W'(b));
    write_reg(REG_KEY_C, DATA_W'(c));
    write_reg(REG_KEY_D, DATA_W'(d));
    write_reg(REG_DECRYPT, {{(DATA_W-1){1'b0}}, dec});
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    key_loads++;
  endtask

  function automatic int rand_key_val();
    int sel;
    sel = $urandom_range(99);
    if (sel < 5) return $urandom_range(31, 26);   // above range, reduced mod 26
    if (sel < 15) return (sel < 10) ? 0 : 25;
    return $urandom_range(25);
  endfunction

  function automatic int rand_letter();
    int sel;
    sel = $urandom_range(99);
    if (sel < 4) return $urandom_range(31, 26);
    if (sel < 10) return (sel < 7) ? 0 : 25;
    return $urandom_range(25);
  endfunction

  initial begin
    int sel;
    rst = 1'b1;
    letters_if.valid       = 1'b0;
    letters_if.letter      = '0;
    letters_if.end_of_text = 1'b0;
    results_if.ready       = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = '0;
    cfg_if.data            = '0;
    key_a_sh = 1;
    key_b_sh = 0;
    key_c_sh = 0;
    key_d_sh = 1;
    decrypt_sh = 1'b0;
    held_ltr  = 0;
    half_held = 1'b0;
    hold_req  = 0;
    hold_seen = 0;
    hold_cnt  = 0;
    in_fire   = 1'b0;
    mismatch_cnt  = 0;
    letters_taken = 0;
    chars_seen    = 0;
    err_chars     = 0;
    dec_chars     = 0;
    reg_writes    = 0;
    key_loads     = 0;
    src_idle_pct  = 10;
    snk_idle_pct  = 50;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset key is identity, encrypt
    send(0, 0);   send(25, 0);
    send(25, 0);  send(0, 1);
    send(13, 1);                      // lone letter at end of text, padded with 0
    send(16, 0);  send(9, 0);

    load_key(3, 3, 2, 5, 1'b0);       // det 9, invertible
    send(7, 0);   send(8, 0);
    send(11, 0);  send(11, 1);
    load_key(3, 3, 2, 5, 1'b1);
    send(15, 0);  send(20, 0);
    send(4, 1);

    load_key(2, 4, 6, 8, 1'b1);       // even det: key error in both modes
    send(1, 0);   send(2, 0);
    load_key(2, 4, 6, 8, 1'b0);
    send(3, 1);
    load_key(25, 25, 25, 25, 1'b0);   // det 0
    send(25, 0);  send(25, 0);
    load_key(0, 0, 0, 0, 1'b1);
    send(0, 1);
    load_key(25, 0, 0, 25, 1'b1);     // det 1
    send(24, 0);  send(25, 0);
    load_key(27, 26, 31, 1, 1'b0);    // register values above 25
    send(30, 0);  send(26, 0);

    // key rewritten while the first letter of a pair is held
    send(5, 0);
    load_key(5, 17, 8, 3, 1'b0);
    send(9, 0);

    for (int rnd = 0; rnd < 14; rnd++) begin
      if (rnd < 5) begin
        src_idle_pct = 10;
        snk_idle_pct = 50;
      end else if (rnd < 10) begin
        src_idle_pct = 50;
        snk_idle_pct = 10;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      sel = $urandom_range(9);
      if (sel == 0)
        load_key(1, 0, 0, 1, 1'($urandom_range(1)));
      else
        load_key(rand_key_val(), rand_key_val(), rand_key_val(), rand_key_val(),
                 1'($urandom_range(1)));
      for (int n = 0; n < 100; n++)
        send(rand_letter(), ($urandom_range(99) < 6));
      // long output stall while letters keep coming
      if (rnd == 10)
        hold_req = hold_req + 1;
    end

    wait_idle();
    $display("covered %0d letter requests, %0d characters (%0d lowercase, %0d key-error)",
             letters_taken, chars_seen, dec_chars, err_chars);
    $display("across %0d key loads (%0d register writes), idle mixes and one long output stall",
             key_loads, reg_writes);
    if (chars_due.size() != 0) begin
      mismatch_cnt += chars_due.size();
      $display("%0d characters never arrived", chars_due.size());
    end
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
rtl/hcm_pkg.sv
rtl/hcm_if.sv
rtl/hcm_key.sv
rtl/hcm_pair.sv
rtl/hcm_out.sv
rtl/hill_cipher_2x2_mod26_top.sv
test/tb.sv
